/* rtl/tnbm_pkg.sv */
package tnbm_pkg;

	// Q3.12 fixed point
	localparam int FRAC_BITS = 12;
	localparam int ONE       = 1 << FRAC_BITS;
	// tanh table: 64 equal segments over [0, 4)
	localparam int SEG_BITS  = 6;
	localparam int SPAN_BITS = FRAC_BITS + 2;
	localparam int FR_BITS   = SPAN_BITS - SEG_BITS;
	localparam int ACC_W     = 40;

	// operations
	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_FWD     = 3'd1;
	localparam logic [2:0] OP_OUTGRAD = 3'd2;
	localparam logic [2:0] OP_HIDGRAD = 3'd3;
	localparam logic [2:0] OP_UPDATE  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_ACT    = 2'd0;
	localparam logic [1:0] KIND_GRAD   = 2'd1;
	localparam logic [1:0] KIND_WEIGHT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_RATE   = 2'd0;
	localparam logic [1:0] REG_MOM    = 2'd1;
	localparam logic [1:0] REG_ACTIVE = 2'd2;

	// multiplier operand selects
	localparam logic [2:0] MS_VW = 3'd0; // input value * stored weight
	localparam logic [2:0] MS_LV = 3'd1; // link weight * next gradient
	localparam logic [2:0] MS_AA = 3'd2; // activation squared
	localparam logic [2:0] MS_ED = 3'd3; // (target - activation) * derivative
	localparam logic [2:0] MS_HD = 3'd4; // (sum >> F) * derivative
	localparam logic [2:0] MS_RI = 3'd5; // rate * stored input
	localparam logic [2:0] MS_PG = 3'd6; // previous product * gradient
	localparam logic [2:0] MS_MD = 3'd7; // momentum * old delta

	typedef struct packed {
		logic       latch;
		logic       use_cnt;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       w_we;
		logic       d_we;
		logic       i_we;
		logic       upd;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       acc_add;
		logic       acc_clr;
		logic       d_ld;
		logic       t1_ld;
		logic       nd_ld;
		logic       grad_ld;
		logic       abs_ld;
		logic       act_ld;
		logic       out_ld;
		logic [1:0] out_src;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       last;
		logic       ok;
		logic       n_zero;
		logic       cnt_last;
		logic       clr_done;
		logic       out_free;
	} sts_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767)
			r = 16'sh7fff;
		else if (v < -48'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// tanh(4i/64) in Q12, rounded
	function automatic logic [12:0] tanh_pt(input logic [6:0] i);
		logic [12:0] r;
		case (i)
			7'd0:  r = 13'd0;
			7'd1:  r = 13'd256;
			7'd2:  r = 13'd509;
			7'd3:  r = 13'd759;
			7'd4:  r = 13'd1003;
			7'd5:  r = 13'd1240;
			7'd6:  r = 13'd1468;
			7'd7:  r = 13'd1686;
			7'd8:  r = 13'd1893;
			7'd9:  r = 13'd2088;
			7'd10: r = 13'd2272;
			7'd11: r = 13'd2443;
			7'd12: r = 13'd2602;
			7'd13: r = 13'd2748;
			7'd14: r = 13'd2884;
			7'd15: r = 13'd3007;
			7'd16: r = 13'd3119;
			7'd17: r = 13'd3222;
			7'd18: r = 13'd3315;
			7'd19: r = 13'd3399;
			7'd20: r = 13'd3475;
			7'd21: r = 13'd3543;
			7'd22: r = 13'd3604;
			7'd23: r = 13'd3659;
			7'd24: r = 13'd3707;
			7'd25: r = 13'd3751;
			7'd26: r = 13'd3790;
			7'd27: r = 13'd3825;
			7'd28: r = 13'd3856;
			7'd29: r = 13'd3883;
			7'd30: r = 13'd3908;
			7'd31: r = 13'd3929;
			7'd32: r = 13'd3949;
			7'd33: r = 13'd3966;
			7'd34: r = 13'd3981;
			7'd35: r = 13'd3994;
			7'd36: r = 13'd4006;
			7'd37: r = 13'd4016;
			7'd38: r = 13'd4026;
			7'd39: r = 13'd4034;
			7'd40: r = 13'd4041;
			7'd41: r = 13'd4048;
			7'd42: r = 13'd4053;
			7'd43: r = 13'd4058;
			7'd44: r = 13'd4063;
			7'd45: r = 13'd4067;
			7'd46: r = 13'd4070;
			7'd47: r = 13'd4073;
			7'd48: r = 13'd4076;
			7'd49: r = 13'd4078;
			7'd50: r = 13'd4080;
			7'd51: r = 13'd4082;
			7'd52: r = 13'd4084;
			7'd53: r = 13'd4085;
			7'd54: r = 13'd4086;
			7'd55: r = 13'd4088;
			7'd56: r = 13'd4089;
			7'd57: r = 13'd4089;
			7'd58: r = 13'd4090;
			7'd59: r = 13'd4091;
			7'd60: r = 13'd4091;
			7'd61: r = 13'd4092;
			7'd62: r = 13'd4092;
			7'd63: r = 13'd4093;
			7'd64: r = 13'd4093;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

endpackage

/* rtl/tnbm_ram.sv */
module tnbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/tnbm_ctrl.sv */
module tnbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tnbm_pkg::sts_t    sts,
	output tnbm_pkg::cmd_t    cmd
);

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_DEC   = 5'd2;
	localparam logic [4:0] ST_W_WR  = 5'd3;
	localparam logic [4:0] ST_F_RD  = 5'd4;
	localparam logic [4:0] ST_F_MUL = 5'd5;
	localparam logic [4:0] ST_F_ACC = 5'd6;
	localparam logic [4:0] ST_T_ABS = 5'd7;
	localparam logic [4:0] ST_T_ACT = 5'd8;
	localparam logic [4:0] ST_EM_A  = 5'd9;
	localparam logic [4:0] ST_G_SQ  = 5'd10;
	localparam logic [4:0] ST_G_D   = 5'd11;
	localparam logic [4:0] ST_G_MUL = 5'd12;
	localparam logic [4:0] ST_G_SAT = 5'd13;
	localparam logic [4:0] ST_EM_G  = 5'd14;
	localparam logic [4:0] ST_H_MUL = 5'd15;
	localparam logic [4:0] ST_H_ACC = 5'd16;
	localparam logic [4:0] ST_U_RD  = 5'd17;
	localparam logic [4:0] ST_U_M1  = 5'd18;
	localparam logic [4:0] ST_U_M2  = 5'd19;
	localparam logic [4:0] ST_U_M3  = 5'd20;
	localparam logic [4:0] ST_U_ND  = 5'd21;
	localparam logic [4:0] ST_U_WR  = 5'd22;

	logic [4:0] state_q;
	logic [4:0] state_nx;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.use_cnt = 1'b1;
				cmd.d_we = 1'b1;
				if (sts.clr_done) begin
					cmd.cnt_clr = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid)
					state_nx = ST_DEC;
			end
			ST_DEC: begin
				case (sts.op)
					tnbm_pkg::OP_LOAD:    state_nx = ST_W_WR;
					tnbm_pkg::OP_FWD:     state_nx = ST_F_RD;
					tnbm_pkg::OP_OUTGRAD: state_nx = ST_G_SQ;
					tnbm_pkg::OP_HIDGRAD: state_nx = ST_H_MUL;
					tnbm_pkg::OP_UPDATE: begin
						cmd.cnt_clr = 1'b1;
						state_nx = sts.n_zero ? ST_IDLE : ST_U_RD;
					end
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_W_WR: begin
				cmd.w_we = sts.ok;
				cmd.d_we = sts.ok;
				state_nx = ST_IDLE;
			end
			ST_F_RD: begin
				cmd.i_we = sts.ok;
				state_nx = ST_F_MUL;
			end
			ST_F_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = tnbm_pkg::MS_VW;
				state_nx = ST_F_ACC;
			end
			ST_F_ACC: begin
				cmd.acc_add = sts.ok;
				state_nx = sts.last ? ST_T_ABS : ST_IDLE;
			end
			ST_T_ABS: begin
				cmd.abs_ld = 1'b1;
				state_nx = ST_T_ACT;
			end
			ST_T_ACT: begin
				cmd.act_ld = 1'b1;
				state_nx = ST_EM_A;
			end
			ST_EM_A: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.out_src = tnbm_pkg::KIND_ACT;
					state_nx = ST_IDLE;
				end
			end
			ST_G_SQ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = tnbm_pkg::MS_AA;
				state_nx = ST_G_D;
			end
			ST_G_D: begin
				cmd.d_ld = 1'b1;
				state_nx = ST_G_MUL;
			end
			ST_G_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = (sts.op == tnbm_pkg::OP_HIDGRAD) ? tnbm_pkg::MS_HD
					: tnbm_pkg::MS_ED;
				state_nx = ST_G_SAT;
			end
			ST_G_SAT: begin
				cmd.grad_ld = 1'b1;
				cmd.acc_clr = (sts.op == tnbm_pkg::OP_HIDGRAD);
				state_nx = ST_EM_G;
			end
			ST_EM_G: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.out_src = tnbm_pkg::KIND_GRAD;
					state_nx = ST_IDLE;
				end
			end
			ST_H_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = tnbm_pkg::MS_LV;
				state_nx = ST_H_ACC;
			end
			ST_H_ACC: begin
				cmd.acc_add = 1'b1;
				state_nx = sts.last ? ST_G_SQ : ST_IDLE;
			end
			ST_U_RD: begin
				cmd.use_cnt = 1'b1;
				state_nx = ST_U_M1;
			end
			ST_U_M1: begin
				cmd.use_cnt = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = tnbm_pkg::MS_RI;
				state_nx = ST_U_M2;
			end
			ST_U_M2: begin
				cmd.use_cnt = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = tnbm_pkg::MS_PG;
				state_nx = ST_U_M3;
			end
			ST_U_M3: begin
				cmd.use_cnt = 1'b1;
				cmd.t1_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = tnbm_pkg::MS_MD;
				state_nx = ST_U_ND;
			end
			ST_U_ND: begin
				cmd.use_cnt = 1'b1;
				cmd.nd_ld = 1'b1;
				state_nx = ST_U_WR;
			end
			ST_U_WR: begin
				cmd.use_cnt = 1'b1;
				if (sts.out_free) begin
					cmd.upd = 1'b1;
					cmd.w_we = 1'b1;
					cmd.d_we = 1'b1;
					cmd.out_ld = 1'b1;
					cmd.out_src = tnbm_pkg::KIND_WEIGHT;
					if (sts.cnt_last) begin
						state_nx = ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_nx = ST_U_RD;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_nx;
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DEC)
		else $error("accepted request not decoded");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result loaded over a pending result");

	a_acc_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.acc_add, cmd.acc_clr, cmd.act_ld}))
		else $error("conflicting accumulator commands");

	a_walk_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_U_WR && cmd.out_ld && !sts.cnt_last |=> state_q == ST_U_RD)
		else $error("update walk stopped early");

endmodule

/* rtl/tnbm_dp.sv */
module tnbm_dp #(
	parameter int MAX_INPUTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tnbm_pkg::cmd_t    cmd,
	output tnbm_pkg::sts_t    sts,
	input  logic [39:0]       in_tdata,
	input  logic [2:0]        in_tuser,
	input  logic              in_tlast,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [12:0]       cfg_wdata,
	output logic              out_tvalid,
	input  logic              out_tready,
	output logic [23:0]       out_tdata,
	output logic [1:0]        out_tuser,
	output logic              out_tlast
);

	localparam int AW = $clog2(MAX_INPUTS);
	localparam int CW = $clog2(MAX_INPUTS + 1);
	localparam int F  = tnbm_pkg::FRAC_BITS;
	localparam int AC = tnbm_pkg::ACC_W;

	// latched request
	logic [2:0]         op_q;
	logic [5:0]         slot_q;
	logic signed [15:0] value_q;
	logic signed [15:0] link_q;
	logic               last_q;

	// configuration
	logic [12:0] rate_q;
	logic [12:0] mom_q;
	logic [6:0]  active_q;

	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        n_lim;
	logic [AW-1:0]        addr;
	logic signed [AC-1:0] acc_q;
	logic signed [15:0]   act_q;
	logic signed [15:0]   grad_q;
	logic signed [17:0]   d_q;
	logic signed [47:0]   mul_q;
	logic signed [23:0]   t1_q;
	logic signed [15:0]   nd_q;
	logic                 neg_q;
	logic [AC-F-1:0]      mag_q;

	logic [15:0] w_rd, i_rd, d_rd;
	logic [15:0] w_wdata, d_wdata;

	logic signed [29:0]   mul_a;
	logic signed [17:0]   mul_b;
	logic signed [47:0]   mul_p;
	logic signed [AC:0]   acc_sum;
	logic signed [AC-1:0] acc_sat;
	logic signed [AC-F-1:0] x_sh;
	logic signed [17:0]   tgt_diff;
	logic signed [15:0]   w_new;
	logic signed [15:0]   nd_nx;

	logic [tnbm_pkg::SEG_BITS-1:0] t_idx;
	logic [tnbm_pkg::FR_BITS-1:0]  t_fr;
	logic [12:0]                   t_p0, t_p1, t_y;
	logic [12+tnbm_pkg::FR_BITS:0] t_prod;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [5:0]  out_slot_q;
	logic [15:0] out_value_q;
	logic        out_last_q;

	assign addr = cmd.use_cnt ? cnt_q[AW-1:0] : AW'(slot_q);

	always_comb begin
		if (32'(active_q) > MAX_INPUTS)
			n_lim = CW'(MAX_INPUTS);
		else
			n_lim = CW'(active_q);
	end

	assign sts.op       = op_q;
	assign sts.last     = last_q;
	assign sts.ok       = (32'(slot_q) < MAX_INPUTS);
	assign sts.n_zero   = (n_lim == '0);
	assign sts.cnt_last = (CW'(cnt_q + CW'(1)) == n_lim);
	assign sts.clr_done = (cnt_q == CW'(MAX_INPUTS - 1));
	assign sts.out_free = !out_valid_q || out_tready;

	// stores
	assign w_new   = tnbm_pkg::sat16(48'($signed(w_rd)) + 48'(nd_q));
	assign w_wdata = cmd.upd ? w_new : value_q;
	assign d_wdata = cmd.upd ? nd_q : 16'd0;

	tnbm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_wram (
		.clk(clk), .we(cmd.w_we), .waddr(addr), .wdata(w_wdata),
		.raddr(addr), .rdata(w_rd)
	);

	tnbm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_dram (
		.clk(clk), .we(cmd.d_we), .waddr(addr), .wdata(d_wdata),
		.raddr(addr), .rdata(d_rd)
	);

	tnbm_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_iram (
		.clk(clk), .we(cmd.i_we), .waddr(addr), .wdata(value_q),
		.raddr(addr), .rdata(i_rd)
	);

	// shared multiplier
	assign tgt_diff = 18'(value_q) - 18'(act_q);
	assign x_sh     = acc_q[AC-1:F];

	always_comb begin
		case (cmd.mul_sel)
			tnbm_pkg::MS_VW: begin
				mul_a = 30'(value_q);
				mul_b = 18'($signed(w_rd));
			end
			tnbm_pkg::MS_LV: begin
				mul_a = 30'(link_q);
				mul_b = 18'(value_q);
			end
			tnbm_pkg::MS_AA: begin
				mul_a = 30'(act_q);
				mul_b = 18'(act_q);
			end
			tnbm_pkg::MS_ED: begin
				mul_a = 30'(tgt_diff);
				mul_b = d_q;
			end
			tnbm_pkg::MS_HD: begin
				mul_a = 30'(x_sh);
				mul_b = d_q;
			end
			tnbm_pkg::MS_RI: begin
				mul_a = $signed({17'd0, rate_q});
				mul_b = 18'($signed(i_rd));
			end
			tnbm_pkg::MS_PG: begin
				mul_a = mul_q[29:0];
				mul_b = 18'(grad_q);
			end
			tnbm_pkg::MS_MD: begin
				mul_a = $signed({17'd0, mom_q});
				mul_b = 18'($signed(d_rd));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// saturating accumulate
	assign acc_sum = {acc_q[AC-1], acc_q} + (AC+1)'($signed(mul_q[31:0]));
	always_comb begin
		if (acc_sum[AC] != acc_sum[AC-1])
			acc_sat = acc_sum[AC] ? {1'b1, {(AC-1){1'b0}}} : {1'b0, {(AC-1){1'b1}}};
		else
			acc_sat = acc_sum[AC-1:0];
	end

	assign nd_nx = tnbm_pkg::sat16(48'(t1_q) + 48'($signed(mul_q[29:F])));

	// tanh interpolation between table points
	assign t_idx  = mag_q[tnbm_pkg::SPAN_BITS-1 -: tnbm_pkg::SEG_BITS];
	assign t_fr   = mag_q[tnbm_pkg::FR_BITS-1:0];
	assign t_p0   = tnbm_pkg::tanh_pt({1'b0, t_idx});
	assign t_p1   = tnbm_pkg::tanh_pt({1'b0, t_idx} + 7'd1);
	assign t_prod = (t_p1 - t_p0) * t_fr;

	always_comb begin
		if (mag_q >= (AC-F)'(1 << tnbm_pkg::SPAN_BITS))
			t_y = 13'(tnbm_pkg::ONE);
		else
			t_y = t_p0 + 13'(t_prod >> tnbm_pkg::FR_BITS);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= in_tuser;
			slot_q  <= in_tdata[5:0];
			value_q <= in_tdata[21:6];
			link_q  <= in_tdata[37:22];
			last_q  <= in_tlast;
		end
		if (cmd.mul_en)
			mul_q <= mul_p;
		if (cmd.d_ld)
			d_q <= 18'(tnbm_pkg::ONE) - 18'(mul_q[47:F]);
		if (cmd.t1_ld)
			t1_q <= mul_q[47:2*F];
		if (cmd.nd_ld)
			nd_q <= nd_nx;
		if (cmd.abs_ld) begin
			neg_q <= x_sh[AC-F-1];
			mag_q <= x_sh[AC-F-1] ? (AC-F)'(-x_sh) : (AC-F)'(x_sh);
		end
		if (cmd.out_ld) begin
			out_kind_q <= cmd.out_src;
			case (cmd.out_src)
				tnbm_pkg::KIND_ACT: begin
					out_slot_q  <= 6'd0;
					out_value_q <= act_q;
					out_last_q  <= 1'b1;
				end
				tnbm_pkg::KIND_GRAD: begin
					out_slot_q  <= 6'd0;
					out_value_q <= grad_q;
					out_last_q  <= 1'b1;
				end
				default: begin
					out_slot_q  <= 6'(cnt_q);
					out_value_q <= w_new;
					out_last_q  <= sts.cnt_last;
				end
			endcase
		end
	end

	// state with defined reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= 13'd205;
			mom_q       <= 13'd3686;
			active_q    <= 7'd64;
			cnt_q       <= '0;
			acc_q       <= '0;
			act_q       <= '0;
			grad_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					tnbm_pkg::REG_RATE:   rate_q   <= cfg_wdata;
					tnbm_pkg::REG_MOM:    mom_q    <= cfg_wdata;
					tnbm_pkg::REG_ACTIVE: active_q <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= CW'(cnt_q + CW'(1));
			if (cmd.acc_add)
				acc_q <= acc_sat;
			else if (cmd.acc_clr || cmd.act_ld)
				acc_q <= '0;
			if (cmd.act_ld)
				act_q <= neg_q ? -16'(t_y) : 16'(t_y);
			if (cmd.grad_ld)
				grad_q <= tnbm_pkg::sat16(48'($signed(mul_q[47:F])));
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {2'b00, out_value_q, out_slot_q};
	assign out_tuser  = out_kind_q;
	assign out_tlast  = out_last_q;

endmodule

/* rtl/tanh_neuron_backprop_momentum.sv */
// Channel   Dir  Group                  Contents
// request   in   s_tvalid/s_tready      tuser: op; tdata: slot, value, link_weight; tlast: last
// result    out  m_tvalid/m_tready      tuser: result_kind; tdata: result_slot, result_value;
//                                       tlast: result_last
// config    in   cfg_we/cfg_addr        0 learn_rate, 1 momentum_factor, 2 active_inputs
//
// One request at a time; the controller walks each through the shared 30x18 multiplier.
// Per request: load writes a weight and clears its delta; forward and hidden gradient elements
// multiply and accumulate, emitting an activation or gradient on the last one; output gradient
// emits a gradient; update walks every active weight (one multiplier pass per product, one
// RAM read per slot). After reset a clearing pass zeroes the delta store with s_tready low.
// A stalled result holds the block at its emit step; the output register frees in the same
// cycle the result is taken.
module tanh_neuron_backprop_momentum #(
	parameter int MAX_INPUTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // slot[5:0], value[21:6], link_weight[37:22], zero pad
	input  logic [2:0]  s_tuser,   // op[2:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // result_slot[5:0], result_value[21:6], zero pad
	output logic [1:0]  m_tuser,   // result_kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata
);

	tnbm_pkg::cmd_t cmd;
	tnbm_pkg::sts_t sts;

	// sequence each request: decode, drive multiplier selects, gate store writes
	tnbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, accumulator, multiplier, tanh lookup and the result register
	tnbm_dp #(.MAX_INPUTS(MAX_INPUTS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_tdata   (s_tdata),
		.in_tuser   (s_tuser),
		.in_tlast   (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_tdata  (m_tdata),
		.out_tuser  (m_tuser),
		.out_tlast  (m_tlast)
	);

endmodule
